// ===== hdl/apiir_pkg.sv =====
// shared types and constants for the all-pole iir filter core
// no dependencies; used by apiir_hist, apiir_mac and all_pole_iir_filter_core
`default_nettype none

package apiir_pkg;

  localparam int unsigned DATA_W    = 24;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned QBITS     = 20;
  localparam int unsigned ORDER_DEF = 16;

  localparam logic signed [DATA_W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [DATA_W-1:0] SMIN = 24'sh800000;

  // item action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FILTER = 1'b1;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;  // clear accumulator
    logic vld;  // coefficient and operand are valid this cycle
    logic sub;  // subtract the product (feedback tap)
  } mac_ctrl_t;

  // control from the sequencer to the output history
  typedef struct packed {
    logic clr;   // clear all entries
    logic rot;   // rotate by one, next older entry to tap 0
    logic push;  // shift in a new newest output
  } hist_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/apiir_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module apiir_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 17
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apiir_hist.sv =====
// output history as a rotating shift line, tap 0 is the only read point
// depends on apiir_pkg
`default_nettype none

module apiir_hist #(
  parameter int unsigned ORDER = apiir_pkg::ORDER_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire apiir_pkg::hist_ctrl_t                   ctrl_i,
  input  wire logic signed [apiir_pkg::DATA_W-1:0]     din_i,
  output logic signed [apiir_pkg::DATA_W-1:0]          tap_o
);

  logic signed [apiir_pkg::DATA_W-1:0] hist_q [ORDER];

  for (genvar i = 0; i < ORDER; i++) begin : g_ent
    logic signed [apiir_pkg::DATA_W-1:0] rot_src;
    logic signed [apiir_pkg::DATA_W-1:0] push_src;

    if (i == ORDER - 1) begin : g_wrap
      assign rot_src = hist_q[0];
    end else begin : g_next
      assign rot_src = hist_q[i+1];
    end

    if (i == 0) begin : g_head
      assign push_src = din_i;
    end else begin : g_prev
      assign push_src = hist_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hist_q[i] <= '0;
      end else if (ctrl_i.clr) begin
        hist_q[i] <= '0;
      end else if (ctrl_i.push) begin
        hist_q[i] <= push_src;
      end else if (ctrl_i.rot) begin
        hist_q[i] <= rot_src;
      end
    end
  end

  assign tap_o = hist_q[0];

endmodule

`default_nettype wire

// ===== hdl/apiir_mac.sv =====
// shared multiply-accumulate unit with rounding and saturation of the sum
// depends on apiir_pkg
`default_nettype none

module apiir_mac #(
  parameter int unsigned ORDER = apiir_pkg::ORDER_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire apiir_pkg::mac_ctrl_t                    ctrl_i,
  input  wire logic signed [apiir_pkg::DATA_W-1:0]     coef_i,
  input  wire logic signed [apiir_pkg::DATA_W-1:0]     opnd_i,
  output logic                                         busy_o,
  output logic signed [apiir_pkg::DATA_W-1:0]          sample_o,
  output logic                                         sat_o
);

  localparam int unsigned ACC_W = apiir_pkg::PROD_W + $clog2(ORDER + 1) + 1;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - apiir_pkg::QBITS){1'b0}}, 1'b1, {(apiir_pkg::QBITS - 1){1'b0}}};

  logic signed [apiir_pkg::PROD_W-1:0] prod_q;
  logic                                s2_v_q;
  logic                                s2_sub_q;
  logic signed [ACC_W-1:0]             acc_q;
  logic signed [ACC_W-1:0]             rsum;
  logic signed [ACC_W-1:0]             rnd;

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= coef_i * opnd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      s2_sub_q <= 1'b0;
    end else begin
      s2_v_q   <= ctrl_i.vld;
      s2_sub_q <= ctrl_i.sub;
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      if (s2_sub_q) begin
        acc_q <= acc_q - ACC_W'(prod_q);
      end else begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  // round to nearest, ties up, then clip
  assign rsum = acc_q + HALF;
  assign rnd  = rsum >>> apiir_pkg::QBITS;

  always_comb begin
    sat_o    = 1'b0;
    sample_o = rnd[apiir_pkg::DATA_W-1:0];
    if (rnd > ACC_W'(apiir_pkg::SMAX)) begin
      sat_o    = 1'b1;
      sample_o = apiir_pkg::SMAX;
    end else if (rnd < ACC_W'(apiir_pkg::SMIN)) begin
      sat_o    = 1'b1;
      sample_o = apiir_pkg::SMIN;
    end
  end

  assign busy_o = s2_v_q;

endmodule

`default_nettype wire

// ===== hdl/all_pole_iir_filter_core.sv =====
// all-pole iir filter core: sequencer, coefficient ram, history line, shared mac
// a sample walks gain and ORDER taps through the single multiply-accumulate
// unit, waits for the read and multiply stages to drain, then rounds into the
// output register once free, then takes a new item; loads stay in idle
// reset: async active low, clears the sequencer, coefficients and output history
// depends on apiir_pkg, apiir_ram, apiir_hist, apiir_mac
`default_nettype none

module all_pole_iir_filter_core #(
  parameter int unsigned ORDER = apiir_pkg::ORDER_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // input channel
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic                                    action_i,
  input  wire logic                                    start_block_i,
  input  wire logic [apiir_pkg::IDX_W-1:0]             coef_index_i,
  input  wire logic signed [apiir_pkg::DATA_W-1:0]     value_i,
  // output channel
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed [apiir_pkg::DATA_W-1:0]          sample_out_o,
  output logic                                         saturated_o
);

  // coefficient address covers gain slot plus ORDER taps
  localparam int unsigned CA_W  = $clog2(ORDER + 1);
  localparam int unsigned CMP_W = (CA_W > apiir_pkg::IDX_W) ? CA_W : apiir_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,  // waiting for a transaction
    ST_MAC   = 4'b0010,  // issuing coefficient reads, one tap per cycle
    ST_WAIT  = 4'b0100,  // draining the read and multiply stages
    ST_ROUND = 4'b1000   // result ready, push to output register and history
  } state_e;

  state_e                              state_q, state_d;
  logic [CA_W-1:0]                     cnt_q;
  logic signed [apiir_pkg::DATA_W-1:0] x_q;
  logic [ORDER:0]                      cvalid_q;
  logic                                cvld_q;
  logic                                s1_v_q;
  logic                                s1_first_q;

  logic                                out_valid_q;
  logic signed [apiir_pkg::DATA_W-1:0] sample_q;
  logic                                sat_q;

  logic                                in_acc;
  logic                                load_acc;
  logic                                filt_acc;
  logic [CMP_W-1:0]                    idx_w;
  logic                                idx_ok;
  logic [CA_W-1:0]                     waddr;
  logic [apiir_pkg::DATA_W-1:0]        rdata;
  logic signed [apiir_pkg::DATA_W-1:0] coef;
  logic signed [apiir_pkg::DATA_W-1:0] opnd;
  logic signed [apiir_pkg::DATA_W-1:0] tap;
  logic signed [apiir_pkg::DATA_W-1:0] y;
  logic                                y_sat;
  logic                                mac_busy;
  logic                                out_free;
  logic                                last_tap;
  apiir_pkg::mac_ctrl_t                mac_ctrl;
  apiir_pkg::hist_ctrl_t               hist_ctrl;

  // input transaction decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (action_i == apiir_pkg::ACT_LOAD);
  assign filt_acc   = in_acc && (action_i == apiir_pkg::ACT_FILTER);

  // loads beyond ORDER are dropped
  assign idx_w  = CMP_W'(coef_index_i);
  assign idx_ok = (idx_w <= CMP_W'(ORDER));
  assign waddr  = idx_w[CA_W-1:0];

  assign last_tap = (cnt_q == CA_W'(ORDER));
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (filt_acc) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_tap) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // accumulator final once both pipeline stages are empty
        if (!s1_v_q && !mac_busy) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // tap counter, doubles as the coefficient read address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (filt_acc) begin
      cnt_q <= '0;
    end else if (state_q == ST_MAC && !last_tap) begin
      cnt_q <= cnt_q + CA_W'(1);
    end
  end

  // input sample, held for the gain product
  always_ff @(posedge clk_i) begin
    if (filt_acc) begin
      x_q <= value_i;
    end
  end

  // per-slot written flags; an unwritten slot reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q <= '0;
    end else if (load_acc && idx_ok) begin
      cvalid_q[waddr] <= 1'b1;
    end
  end

  apiir_ram #(
    .WIDTH (apiir_pkg::DATA_W),
    .DEPTH (ORDER + 1)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc && idx_ok),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (state_q == ST_MAC),
    .raddr_i (cnt_q),
    .rdata_o (rdata)
  );

  // read stage flags, aligned with the registered ram data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_first_q <= 1'b0;
      cvld_q     <= 1'b0;
    end else begin
      s1_v_q     <= (state_q == ST_MAC);
      s1_first_q <= (cnt_q == '0);
      cvld_q     <= cvalid_q[cnt_q];
    end
  end

  assign coef = cvld_q ? $signed(rdata) : '0;
  // gain uses the input sample, taps use the history line in age order
  assign opnd = s1_first_q ? x_q : tap;

  always_comb begin
    mac_ctrl.clr = filt_acc;
    mac_ctrl.vld = s1_v_q;
    mac_ctrl.sub = !s1_first_q;
  end

  // history rotates once per tap, ORDER times in all, so it is back in place
  always_comb begin
    hist_ctrl.clr  = filt_acc && start_block_i;
    hist_ctrl.rot  = s1_v_q && !s1_first_q;
    hist_ctrl.push = (state_q == ST_ROUND) && out_free;
  end

  apiir_hist #(
    .ORDER (ORDER)
  ) u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hist_ctrl),
    .din_i  (y),
    .tap_o  (tap)
  );

  apiir_mac #(
    .ORDER (ORDER)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef),
    .opnd_i   (opnd),
    .busy_o   (mac_busy),
    .sample_o (y),
    .sat_o    (y_sat)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (hist_ctrl.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_ctrl.push) begin
      sample_q <= y;
      sat_q    <= y_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign saturated_o  = sat_q;

  // result is taken only after the mac pipeline has drained
  a_round_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (!s1_v_q && !mac_busy))
    else $error("rounding with products still in flight");

  // a sample transaction always starts the tap walk
  a_filt_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_acc |=> (state_q == ST_MAC && cnt_q == '0))
    else $error("sample transaction did not start the tap walk");

  // read stage is busy only while a sample is in work
  a_s1_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (state_q == ST_MAC || state_q == ST_WAIT))
    else $error("read stage active outside a sample");

  // the last tap read ends the walk
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && last_tap) |=> (state_q == ST_WAIT))
    else $error("tap walk overran ORDER");

endmodule

`default_nettype wire
